### src/ts_pid_demux_router_defines.svh
// Assertion macros shared by the PID demux router RTL.
// Needs signals named clock and reset in the including module's scope.
`ifndef TS_PID_DEMUX_ROUTER_DEFINES_SVH
`define TS_PID_DEMUX_ROUTER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define TPDR_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define TPDR_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

### src/tpdr_pkg.sv
// Types and fixed constants of the transport stream PID demux router.
// No dependencies; imported by ts_pid_demux_router, ts_route_checker and testbench.
`default_nettype none

package tpdr_pkg;

   // Transport stream sync byte and header field masks.
   localparam logic [7:0] SYNC_BYTE      = 8'h47;
   localparam logic [7:0] PID_HIGH_MASK  = 8'h1F;
   localparam logic [7:0] TEI_MASK       = 8'h80;
   localparam logic [7:0] SCRAMBLE_MASK  = 8'hC0;

   // Configuration register indexes.
   localparam int         CSR_ADDR_W        = 3;
   localparam int         CSR_DATA_W        = 22;
   localparam logic [2:0] CSR_INPUT_MODE    = 3'd0;
   localparam logic [2:0] CSR_ACTIVE_CHAINS = 3'd1;
   localparam int         CSR_PID_SLOT_BASE = 2;

   // Input modes.
   localparam logic MODE_RAW = 1'b0;
   localparam logic MODE_TS  = 1'b1;

   // Positions by which the delay memory read runs ahead of its output.
   localparam int LOOKAHEAD = 4;

   // PID slot register layout.
   localparam int SLOT_VALID_BIT = 21;
   localparam int SLOT_MASK_LSB  = 13;
   localparam int PID_W          = 13;

   // One result beat.
   typedef struct packed {
      logic       scrambled;
      logic       transport_error;
      logic       packet_last;
      logic       packet_first;
      logic [7:0] dest_mask;
      logic [7:0] out_byte;
   } rsp_beat_type;

   typedef struct packed {
      logic             valid;
      logic [7:0]       chain_mask;
      logic [PID_W-1:0] pid;
   } pid_slot_type;

endpackage

`default_nettype wire

### src/ts_pid_demux_router.sv
// Transport stream PID demux router: top level with delay memory, sync hunt,
// PID routing and a two-entry output stage. Depends on tpdr_pkg and the
// assertion macros in ts_pid_demux_router_defines.svh.
//
//   Channel   Direction  Beat contents
//   req_      in         tdata[7:0] in_byte
//   rsp_      out        tdata[7:0] out_byte, tdata[15:8] dest_mask, tlast packet_last,
//                        tuser[0] packet_first, tuser[1] transport_error, tuser[2] scrambled
//   csr_      in         we, addr (register index), wdata (22 bits), no read-back
//
// A byte is taken every cycle while req_tready is high; a result is registered
// the cycle after its byte is accepted. In stream mode a byte leaves PACKET_BYTES
// accepted beats after it entered, through one simple dual-port delay memory that
// is written and read once per beat. A read runs four positions ahead of the
// output so the packet header is already held in registers at the sync byte.
// Reset is synchronous; the delay memory is not cleared, it refills after reset
// or a mode write. req_tready drops only while both output entries are full.
`default_nettype none

`include "ts_pid_demux_router_defines.svh"

module ts_pid_demux_router
   import tpdr_pkg::*;
#(
   parameter int PACKET_BYTES  = 188,
   parameter int NUM_CHAINS    = 8,
   parameter int NUM_PID_SLOTS = 6
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Input stream.
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] in_byte
   // Result stream.
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [15:0]           rsp_tdata,   // [7:0] out_byte, [15:8] dest_mask
   output      logic                  rsp_tlast,   // packet_last
   output      logic [2:0]            rsp_tuser,   // [0] packet_first, [1] transport_error,
                                                   // [2] scrambled
   // Configuration writes.
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int               PTR_W    = $clog2(PACKET_BYTES);
   localparam int               CNT_W    = $clog2(PACKET_BYTES + 1);
   localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(PACKET_BYTES - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(PACKET_BYTES);
   localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W+1)'(PACKET_BYTES);
   localparam logic [7:0]       CHAIN_LIMIT = 8'((9'd1 << NUM_CHAINS) - 9'd1);

   // Configuration registers.
   logic                       input_mode_ff;
   logic [7:0]                 active_chains_ff;
   pid_slot_type               pid_slot_ff [NUM_PID_SLOTS];

   // Stream state.
   logic [CNT_W-1:0]           fill_count_ff,  fill_count_in;
   logic [PTR_W-1:0]           write_pos_ff,   write_pos_in;
   logic [PTR_W-1:0]           packet_pos_ff,  packet_pos_in;
   logic                       sync_locked_ff, sync_locked_in;
   logic [7:0]                 route_mask_ff,  route_mask_in;
   logic                       route_tei_ff,   route_tei_in;
   logic                       route_scr_ff,   route_scr_in;

   // Delay memory and the header window ahead of its output.
   logic [7:0]                 delay_mem [PACKET_BYTES];
   logic [7:0]                 rd_data_ff;
   logic [7:0]                 head0_ff, head1_ff, head2_ff;
   logic [PTR_W-1:0]           rd_addr;
   logic [PTR_W:0]             ahead_sum;

   // Output register and skid entry.
   logic                       out_valid_ff,  out_valid_in;
   logic                       skid_valid_ff, skid_valid_in;
   rsp_beat_type               out_ff,  out_in;
   rsp_beat_type               skid_ff, skid_in;

   logic                       req_fire;
   logic                       rsp_fire;
   logic                       ts_step;
   logic                       res_valid;
   rsp_beat_type               res;

   assign req_tready = !skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = out_valid_ff && rsp_tready;
   assign ts_step    = req_fire && (input_mode_ff == MODE_TS);

   // Read address runs LOOKAHEAD entries ahead of the write pointer.
   assign ahead_sum = {1'b0, write_pos_ff} + (PTR_W+1)'(LOOKAHEAD);
   assign rd_addr   = (ahead_sum >= DEPTH_X) ? PTR_W'(ahead_sum - DEPTH_X)
                                             : ahead_sum[PTR_W-1:0];

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         input_mode_ff    <= MODE_RAW;
         active_chains_ff <= '0;
         for (int s = 0; s < NUM_PID_SLOTS; s++) begin
            pid_slot_ff[s] <= '0;
         end
      end else if (csr_we) begin
         if (csr_addr == CSR_INPUT_MODE) begin
            input_mode_ff <= csr_wdata[0];
         end
         if (csr_addr == CSR_ACTIVE_CHAINS) begin
            active_chains_ff <= csr_wdata[7:0];
         end
         for (int s = 0; s < NUM_PID_SLOTS; s++) begin
            if (csr_addr == CSR_ADDR_W'(CSR_PID_SLOT_BASE + s)) begin
               pid_slot_ff[s] <= pid_slot_type'(csr_wdata);
            end
         end
      end
   end

   // Delay memory: one write and one lookahead read per stream beat.
   always_ff @(posedge clock) begin
      if (ts_step) begin
         delay_mem[write_pos_ff] <= req_tdata;
         rd_data_ff              <= delay_mem[rd_addr];
         head0_ff                <= head1_ff;
         head1_ff                <= head2_ff;
         head2_ff                <= rd_data_ff;
      end
   end

   // Per-beat stream step: sync hunt, routing at the sync byte, result forming.
   always_comb begin
      logic             lock_now;
      logic             locked_eff;
      logic [PTR_W-1:0] pos_eff;
      logic [PID_W-1:0] pid;
      logic [7:0]       match_mask;
      logic [7:0]       mask_use;
      logic             tei_use;
      logic             scr_use;
      logic             emit;

      fill_count_in  = fill_count_ff;
      write_pos_in   = write_pos_ff;
      packet_pos_in  = packet_pos_ff;
      sync_locked_in = sync_locked_ff;
      route_mask_in  = route_mask_ff;
      route_tei_in   = route_tei_ff;
      route_scr_in   = route_scr_ff;
      res_valid      = 1'b0;
      res            = '0;

      // PID lookup over the header held ahead of the output byte.
      pid        = {head1_ff[4:0] & PID_HIGH_MASK[4:0], head2_ff};
      match_mask = '0;
      for (int s = 0; s < NUM_PID_SLOTS; s++) begin
         if (pid_slot_ff[s].valid && (pid_slot_ff[s].pid == pid)) begin
            match_mask = match_mask | pid_slot_ff[s].chain_mask;
         end
      end

      lock_now   = !sync_locked_ff && (head0_ff == SYNC_BYTE) && (req_tdata == SYNC_BYTE);
      locked_eff = sync_locked_ff || lock_now;
      pos_eff    = lock_now ? '0 : packet_pos_ff;
      emit       = 1'b0;
      mask_use   = route_mask_ff;
      tei_use    = route_tei_ff;
      scr_use    = route_scr_ff;

      if (req_fire && (input_mode_ff == MODE_RAW)) begin
         // Raw pass-through to all active chains.
         res.out_byte  = req_tdata;
         res.dest_mask = active_chains_ff & CHAIN_LIMIT;
         res_valid     = (res.dest_mask != '0);
      end else if (ts_step) begin
         if (fill_count_ff >= FULL_CNT) begin
            if (locked_eff) begin
               sync_locked_in = 1'b1;
               emit           = 1'b1;
               if (pos_eff == '0) begin
                  if (head0_ff != SYNC_BYTE) begin
                     // Lost sync: drop the packet and hunt again.
                     sync_locked_in = 1'b0;
                     route_mask_in  = '0;
                     route_tei_in   = 1'b0;
                     route_scr_in   = 1'b0;
                     emit           = 1'b0;
                  end else begin
                     mask_use      = match_mask & active_chains_ff & CHAIN_LIMIT;
                     tei_use       = (head1_ff & TEI_MASK) != '0;
                     scr_use       = (rd_data_ff & SCRAMBLE_MASK) != '0;
                     route_mask_in = mask_use;
                     route_tei_in  = tei_use;
                     route_scr_in  = scr_use;
                  end
               end
               if (emit) begin
                  packet_pos_in = (pos_eff == LAST_POS) ? '0 : pos_eff + 1'b1;
               end else begin
                  packet_pos_in = pos_eff;
               end
               res.out_byte        = head0_ff;
               res.dest_mask       = mask_use;
               res.packet_first    = (pos_eff == '0);
               res.packet_last     = (pos_eff == LAST_POS);
               res.transport_error = tei_use;
               res.scrambled       = scr_use;
               res_valid           = emit && (mask_use != '0);
            end
         end else begin
            fill_count_in = fill_count_ff + 1'b1;
         end
         write_pos_in = (write_pos_ff == LAST_POS) ? '0 : write_pos_ff + 1'b1;
      end
   end

   // Stream state registers; a mode write restarts the stream.
   always_ff @(posedge clock) begin
      if (reset || (csr_we && (csr_addr == CSR_INPUT_MODE))) begin
         fill_count_ff  <= '0;
         write_pos_ff   <= '0;
         packet_pos_ff  <= '0;
         sync_locked_ff <= 1'b0;
         route_mask_ff  <= '0;
         route_tei_ff   <= 1'b0;
         route_scr_ff   <= 1'b0;
      end else begin
         fill_count_ff  <= fill_count_in;
         write_pos_ff   <= write_pos_in;
         packet_pos_ff  <= packet_pos_in;
         sync_locked_ff <= sync_locked_in;
         route_mask_ff  <= route_mask_in;
         route_tei_ff   <= route_tei_in;
         route_scr_ff   <= route_scr_in;
      end
   end

   // Output register with a skid entry behind it.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (rsp_fire) begin
         out_valid_in  = skid_valid_ff;
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end
      if (res_valid) begin
         if (!out_valid_in) begin
            out_valid_in = 1'b1;
            out_in       = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.dest_mask, out_ff.out_byte};
   assign rsp_tlast  = out_ff.packet_last;
   assign rsp_tuser  = {out_ff.scrambled, out_ff.transport_error, out_ff.packet_first};

   // Checks on the output stage and the stream pointers.
   `TPDR_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_ff || out_valid_ff, "skid entry without output beat")
   `TPDR_ASSERT_IMPLY(a_mask_nonzero, out_valid_ff, out_ff.dest_mask != '0, "result beat with empty mask")
   `TPDR_ASSERT_ALWAYS(a_ptr_range, (packet_pos_ff <= LAST_POS) && (write_pos_ff <= LAST_POS), "stream pointer out of range")
   `TPDR_ASSERT_IMPLY(a_first_is_sync, out_valid_ff && out_ff.packet_first, out_ff.out_byte == SYNC_BYTE, "packet start is not a sync byte")

endmodule

`default_nettype wire

### test/ts_route_checker.sv
// Scoreboard for the transport stream PID demux router: watches the input, result and
// register ports, predicts every result beat and compares it field by field.
// Needs tpdr_pkg for the beat and PID slot layouts and the header constants.
`timescale 1ns / 1ps

module ts_route_checker
   import tpdr_pkg::*;
#(
   parameter int PACKET_BYTES  = 188,
   parameter int NUM_CHAINS    = 8,
   parameter int NUM_PID_SLOTS = 6
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] in_byte
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [15:0]           rsp_tdata,   // [7:0] out_byte, [15:8] dest_mask
   input  wire logic                  rsp_tlast,   // packet_last
   input  wire logic [2:0]            rsp_tuser,   // [0] packet_first, [1] transport_error,
                                                   // [2] scrambled
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         beat_errors,
   output int                         beats_in_flight
);

   localparam int         SLOT_REGS    = 6;
   localparam int         REPORT_LIMIT = 100;
   localparam logic [7:0] CHAIN_LIMIT  = 8'((1 << NUM_CHAINS) - 1);

   // Register copies.
   logic         stream_mode;
   logic [7:0]   chain_enable;
   pid_slot_type pid_table [0:SLOT_REGS-1];

   // Stream state: the packet-long delay line and the sync and routing status.
   logic [7:0]   delay_line [0:PACKET_BYTES-1];
   int           bytes_held;
   int           line_pos;
   int           byte_in_packet;
   logic         in_sync;
   logic [7:0]   packet_dests;
   logic         packet_tei;
   logic         packet_scrambled;

   rsp_beat_type routed_beats [$];
   int           reports;

   function automatic string describe(input rsp_beat_type b);
      return $sformatf("byte %02h dests %02h first %0b last %0b tei %0b scrambled %0b",
                       b.out_byte, b.dest_mask, b.packet_first, b.packet_last,
                       b.transport_error, b.scrambled);
   endfunction

   function automatic void restart_stream();
      bytes_held       = 0;
      line_pos         = 0;
      byte_in_packet   = 0;
      in_sync          = 1'b0;
      packet_dests     = '0;
      packet_tei       = 1'b0;
      packet_scrambled = 1'b0;
   endfunction

   function automatic void apply_register(input logic [CSR_ADDR_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] value);
      if (idx == CSR_INPUT_MODE) begin
         // A mode write also throws away the stream state.
         stream_mode = value[0];
         restart_stream();
      end else if (idx == CSR_ACTIVE_CHAINS) begin
         chain_enable = value[7:0];
      end else if (idx >= CSR_PID_SLOT_BASE && idx < CSR_PID_SLOT_BASE + SLOT_REGS) begin
         pid_table[idx - CSR_PID_SLOT_BASE] = value[21:0];
      end
   endfunction

   // Reads the header of the packet whose sync byte is leaving the delay line and
   // works out its destinations and flags.
   function automatic void route_header();
      logic [7:0]       b1;
      logic [7:0]       b2;
      logic [7:0]       b3;
      logic [7:0]       hi;
      logic [PID_W-1:0] pid;
      logic [7:0]       dests;
      b1 = delay_line[(line_pos + 1) % PACKET_BYTES];
      b2 = delay_line[(line_pos + 2) % PACKET_BYTES];
      b3 = delay_line[(line_pos + 3) % PACKET_BYTES];
      hi = b1 & PID_HIGH_MASK;
      pid = {hi[4:0], b2};
      dests = '0;
      for (int s = 0; s < NUM_PID_SLOTS; s++) begin
         if (pid_table[s].valid && pid_table[s].pid == pid)
            dests = dests | pid_table[s].chain_mask;
      end
      packet_dests     = dests & chain_enable & CHAIN_LIMIT;
      packet_tei       = |(b1 & TEI_MASK);
      packet_scrambled = |(b3 & SCRAMBLE_MASK);
   endfunction

   // Takes one accepted input byte and queues the result beat that it causes, if any.
   function automatic void route_stream_byte(input logic [7:0] in_byte);
      rsp_beat_type beat;
      logic [7:0]   old_byte;
      logic         emit;
      beat = '0;
      if (stream_mode == MODE_RAW) begin
         if ((chain_enable & CHAIN_LIMIT) != 0) begin
            beat.out_byte  = in_byte;
            beat.dest_mask = chain_enable & CHAIN_LIMIT;
            routed_beats = {routed_beats, beat};
         end
         return;
      end
      if (bytes_held >= PACKET_BYTES) begin
         old_byte = delay_line[line_pos];
         // While hunting, two sync bytes one packet apart give the lock.
         if (!in_sync && old_byte == SYNC_BYTE && in_byte == SYNC_BYTE) begin
            in_sync        = 1'b1;
            byte_in_packet = 0;
         end
         if (in_sync) begin
            emit = 1'b1;
            if (byte_in_packet == 0) begin
               if (old_byte != SYNC_BYTE) begin
                  // A bad sync byte drops the packet and the lock.
                  in_sync          = 1'b0;
                  packet_dests     = '0;
                  packet_tei       = 1'b0;
                  packet_scrambled = 1'b0;
                  emit             = 1'b0;
               end else begin
                  route_header();
               end
            end
            if (in_sync) begin
               if (emit && packet_dests != 0) begin
                  beat.out_byte        = old_byte;
                  beat.dest_mask       = packet_dests;
                  beat.packet_first    = (byte_in_packet == 0);
                  beat.packet_last     = (byte_in_packet == PACKET_BYTES - 1);
                  beat.transport_error = packet_tei;
                  beat.scrambled       = packet_scrambled;
                  routed_beats = {routed_beats, beat};
               end
               byte_in_packet = (byte_in_packet + 1 >= PACKET_BYTES) ? 0 : byte_in_packet + 1;
            end
         end
      end else begin
         bytes_held++;
      end
      delay_line[line_pos] = in_byte;
      line_pos = (line_pos + 1 >= PACKET_BYTES) ? 0 : line_pos + 1;
   endfunction

   // Results are checked before the new input beat is predicted, since a byte
   // accepted at this edge cannot have its result out yet.
   always @(posedge clock) begin : watch
      rsp_beat_type seen;
      rsp_beat_type want;
      if (reset) begin
         stream_mode  = MODE_RAW;
         chain_enable = '0;
         for (int s = 0; s < SLOT_REGS; s++)
            pid_table[s] = '0;
         for (int i = 0; i < PACKET_BYTES; i++)
            delay_line[i] = '0;
         restart_stream();
         routed_beats.delete();
         beat_errors = 0;
         reports     = 0;
      end else begin
         if (csr_we)
            apply_register(csr_addr, csr_wdata);
         if (rsp_tvalid && rsp_tready) begin
            seen.out_byte        = rsp_tdata[7:0];
            seen.dest_mask       = rsp_tdata[15:8];
            seen.packet_last     = rsp_tlast;
            seen.packet_first    = rsp_tuser[0];
            seen.transport_error = rsp_tuser[1];
            seen.scrambled       = rsp_tuser[2];
            if (routed_beats.size() == 0) begin
               beat_errors++;
               if (reports < REPORT_LIMIT)
                  $display("%0t: result beat with none expected, got %s", $time,
                           describe(seen));
               reports++;
            end else begin
               want = routed_beats.pop_front();
               if (seen.out_byte !== want.out_byte || seen.dest_mask !== want.dest_mask ||
                   seen.packet_first !== want.packet_first ||
                   seen.packet_last !== want.packet_last ||
                   seen.transport_error !== want.transport_error ||
                   seen.scrambled !== want.scrambled) begin
                  beat_errors++;
                  if (reports < REPORT_LIMIT)
                     $display("%0t: result beat differs, expected %s, got %s", $time,
                              describe(want), describe(seen));
                  reports++;
               end
            end
         end
         if (req_tvalid && req_tready)
            route_stream_byte(req_tdata);
      end
      beats_in_flight = routed_beats.size();
   end

endmodule

### test/testbench.sv
// Top of the PID demux router test: clock, reset, byte and register stimulus,
// receiver stalls, watchdog and verdict. Needs tpdr_pkg, the RTL and ts_route_checker.
`timescale 1ns / 1ps

module testbench;
   import tpdr_pkg::*;

   localparam int PACKET_LEN     = 188;
   localparam int CHAIN_COUNT    = 8;
   localparam int SLOT_COUNT     = 6;
   localparam int RESET_CYCLES   = 8;
   localparam int DRAIN_CYCLES   = 4;
   localparam int SQUEEZE_CYCLES = 300;
   localparam int QUIET_LIMIT    = 2000;
   localparam int RANDOM_BYTES   = 1600;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;
   logic                  rsp_tlast;
   logic [2:0]            rsp_tuser;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   int                    beat_errors;
   int                    beats_in_flight;

   // Stimulus controls; calm and squeeze_armed are shared with the receiver.
   logic        calm          = 1'b0;
   logic        squeeze_armed = 1'b0;
   logic        ts_mode       = 1'b0;
   int          bytes_sent    = 0;
   logic [12:0] slot_pid [0:SLOT_COUNT-1];

   always #1 clock = ~clock;

   ts_pid_demux_router #(
      .PACKET_BYTES (PACKET_LEN),
      .NUM_CHAINS   (CHAIN_COUNT),
      .NUM_PID_SLOTS(SLOT_COUNT)
   ) dut (.*);

   ts_route_checker #(
      .PACKET_BYTES (PACKET_LEN),
      .NUM_CHAINS   (CHAIN_COUNT),
      .NUM_PID_SLOTS(SLOT_COUNT)
   ) route_check (.*);

   // Offers one byte, after an occasional idle burst, and waits until it is accepted.
   task automatic push_byte(input logic [7:0] value);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 7) == 0)
         gap = $urandom_range(1, 7);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // Stops offering and waits until every predicted beat has come out.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (beats_in_flight != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic program_slot(input int s, input logic valid, input logic [7:0] mask,
                               input logic [12:0] pid);
      pid_slot_type          slot;
      logic [CSR_ADDR_W-1:0] idx;
      slot.valid      = valid;
      slot.chain_mask = mask;
      slot.pid        = pid;
      idx = CSR_ADDR_W'(CSR_PID_SLOT_BASE + s);
      slot_pid[s] = pid;
      write_reg(idx, slot);
   endtask

   // Rewrites the slots (all of them, or each with even odds) with PIDs often set to
   // 0 or 1FFF so that packets often hit more than one slot.
   task automatic reroute_slots(input logic every_slot);
      logic [12:0] pid;
      logic [7:0]  mask;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         if (every_slot || $urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 3))
               0: pid = '0;
               1: pid = 13'h1FFF;
               default: pid = 13'($urandom);
            endcase
            mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
            program_slot(s, every_slot || $urandom_range(0, 6) != 0, mask, pid);
         end
      end
   endtask

   task automatic pick_chains();
      logic [7:0] chains;
      case ($urandom_range(0, 5))
         0: chains = '0;
         1: chains = 8'hFF;
         default: chains = 8'($urandom);
      endcase
      write_reg(CSR_ACTIVE_CHAINS, CSR_DATA_W'(chains));
   endtask

   // One transport packet: sync byte (or a broken one), header and random payload.
   task automatic push_packet(input logic [12:0] pid, input logic tei, input logic [1:0] scr,
                              input logic sync_ok);
      logic [7:0] head;
      head = SYNC_BYTE;
      if (!sync_ok) begin
         head = 8'($urandom);
         if (head == SYNC_BYTE)
            head = ~SYNC_BYTE;
      end
      push_byte(head);
      head = 8'($urandom);
      head[7] = tei;
      head[4:0] = pid[12:8];
      push_byte(head);
      push_byte(pid[7:0]);
      head = 8'($urandom);
      head[7:6] = scr;
      push_byte(head);
      repeat (PACKET_LEN - 4) push_byte(8'($urandom));
   endtask

   // Mostly well-formed packets aimed at the slots, with some stray PIDs, broken
   // sync bytes and junk runs that knock the stream out of alignment.
   task automatic random_packet();
      logic [12:0] pid;
      int          junk;
      if ($urandom_range(0, 9) == 0) begin
         junk = $urandom_range(1, 120);
         repeat (junk) push_byte(8'($urandom));
      end
      if ($urandom_range(0, 3) == 0)
         pid = 13'($urandom);
      else
         pid = slot_pid[$urandom_range(0, SLOT_COUNT - 1)];
      push_packet(pid, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                  $urandom_range(0, 12) != 0);
   endtask

   initial begin : stimulus
      int phase_bytes;
      for (int s = 0; s < SLOT_COUNT; s++)
         slot_pid[s] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Raw mode with no active chain swallows every byte.
      write_reg(CSR_INPUT_MODE, CSR_DATA_W'(MODE_RAW));
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(SYNC_BYTE);
      push_byte(8'hA5);
      settle();

      // Raw mode to all chains, then to the lowest and the highest chain alone.
      write_reg(CSR_ACTIVE_CHAINS, CSR_DATA_W'(8'hFF));
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(SYNC_BYTE);
      push_byte(8'h5A);
      push_byte(8'h01);
      push_byte(8'h80);
      settle();
      write_reg(CSR_ACTIVE_CHAINS, CSR_DATA_W'(8'h01));
      push_byte(8'hFF);
      push_byte(8'h00);
      push_byte(8'h7E);
      settle();
      write_reg(CSR_ACTIVE_CHAINS, CSR_DATA_W'(8'h80));
      push_byte(8'h81);
      push_byte(8'h18);
      settle();

      // Stream mode: overlapping slots, an invalid slot that would match, the
      // all-zero and all-ones slot words, PIDs at both ends of the range.
      program_slot(0, 1'b1, 8'hFF, 13'h1FFF);
      program_slot(1, 1'b1, 8'h0F, 13'h0000);
      program_slot(2, 1'b0, 8'h00, 13'h0000);
      program_slot(3, 1'b1, 8'hFF, 13'h1FFF);
      program_slot(4, 1'b0, 8'hFF, 13'h0100);
      program_slot(5, 1'b1, 8'h30, 13'h0100);
      write_reg(CSR_ACTIVE_CHAINS, CSR_DATA_W'(8'hFF));
      write_reg(CSR_INPUT_MODE, CSR_DATA_W'(MODE_TS));
      ts_mode = 1'b1;
      push_packet(13'h1FFF, 1'b1, 2'd3, 1'b1);
      push_packet(13'h0000, 1'b0, 2'd0, 1'b1);
      // The receiver holds off for a long stretch while this packet goes in.
      squeeze_armed = 1'b1;
      push_packet(13'h0100, 1'b0, 2'd1, 1'b1);
      // No slot matches this one, and the next has a bad sync byte.
      push_packet(13'h0AAA, 1'b0, 2'd2, 1'b1);
      push_packet(13'h0000, 1'b1, 2'd0, 1'b0);
      push_packet(13'h1FFF, 1'b0, 2'd0, 1'b1);
      push_packet(13'h0000, 1'b0, 2'd2, 1'b1);
      settle();

      // Narrower chain enables gate packets already sitting in the delay line.
      write_reg(CSR_ACTIVE_CHAINS, CSR_DATA_W'(8'h0C));
      push_packet(13'h0100, 1'b1, 2'd1, 1'b1);

      // Random phases, mostly stream mode with new routing between phases.
      while (bytes_sent < RANDOM_BYTES) begin
         settle();
         if ($urandom_range(0, 5) == 0) begin
            if (ts_mode || $urandom_range(0, 3) == 0) begin
               write_reg(CSR_INPUT_MODE, CSR_DATA_W'(MODE_RAW));
               ts_mode = 1'b0;
            end
            pick_chains();
            phase_bytes = $urandom_range(40, 100);
            repeat (phase_bytes) push_byte(8'($urandom));
         end else begin
            reroute_slots(1'b0);
            pick_chains();
            if (!ts_mode || $urandom_range(0, 2) == 0) begin
               write_reg(CSR_INPUT_MODE, CSR_DATA_W'(MODE_TS));
               ts_mode = 1'b1;
            end
            repeat ($urandom_range(2, 3)) random_packet();
         end
      end

      // Last stretch at full rate on both sides.
      settle();
      calm <= 1'b1;
      reroute_slots(1'b1);
      write_reg(CSR_ACTIVE_CHAINS, CSR_DATA_W'(8'hFF));
      write_reg(CSR_INPUT_MODE, CSR_DATA_W'(MODE_TS));
      repeat (2) random_packet();
      settle();

      if (beat_errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Result side: random stall bursts, plus one long hold-off when armed.
   initial begin : receiver
      int   hold;
      logic squeezed;
      hold = 0;
      squeezed = 1'b0;
      forever begin
         @(negedge clock);
         if (squeeze_armed && !squeezed) begin
            hold = SQUEEZE_CYCLES;
            squeezed = 1'b1;
         end else if (hold == 0 && !calm && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 7);
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Ends the run when no beat or register write has happened for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            quiet = 0;
         else
            quiet++;
      end
      $display("end of test: mismatches");
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/tpdr_pkg.sv
src/ts_pid_demux_router.sv
test/ts_route_checker.sv
test/testbench.sv
